FILE: hw/rtl/text_terminal_cursor_scroll_defines.svh
// Assertion macros for the text terminal block.
// Used by the top level only; depends on nothing else.
`ifndef TEXT_TERMINAL_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_TERMINAL_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define TTCS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ttcs: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define TTCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ttcs: next-cycle check failed");

`endif

FILE: hw/rtl/ttcs_pkg.sv
// Shared types, constants, microcode and helper functions for the text terminal.
// Used by ttcs_useq, ttcs_datapath and text_terminal_cursor_scroll.
`default_nettype none

package ttcs_pkg;

  // Screen geometry
  localparam int ROWS   = 24;
  localparam int COLS   = 40;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int CHAR_W = 7;
  localparam int ADDR_W = $clog2(CELLS);

  // Character codes
  localparam logic [CHAR_W-1:0] CODE_CR    = 7'h0D;
  localparam logic [CHAR_W-1:0] CODE_LOW   = 7'h20;
  localparam logic [CHAR_W-1:0] CODE_HIGH  = 7'h5F;
  localparam logic [CHAR_W-1:0] CODE_SPACE = 7'h20;

  // Request op codes
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Datapath actions
  localparam int ACT_W = 4;
  localparam logic [ACT_W-1:0] A_NONE   = 4'd0;
  localparam logic [ACT_W-1:0] A_EMIT   = 4'd1;
  localparam logic [ACT_W-1:0] A_LOAD   = 4'd2;
  localparam logic [ACT_W-1:0] A_FILL   = 4'd3;
  localparam logic [ACT_W-1:0] A_WRITE  = 4'd4;
  localparam logic [ACT_W-1:0] A_NEWL   = 4'd5;
  localparam logic [ACT_W-1:0] A_RDADDR = 4'd6;
  localparam logic [ACT_W-1:0] A_RDCAP  = 4'd7;
  localparam logic [ACT_W-1:0] A_CLEAR  = 4'd8;

  // Jump conditions
  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] JC_NEVER     = 4'd0;
  localparam logic [COND_W-1:0] JC_ALWAYS    = 4'd1;
  localparam logic [COND_W-1:0] JC_OUT_BUSY  = 4'd2;
  localparam logic [COND_W-1:0] JC_NO_REQ    = 4'd3;
  localparam logic [COND_W-1:0] JC_OP_READ   = 4'd4;
  localparam logic [COND_W-1:0] JC_OP_CLEAR  = 4'd5;
  localparam logic [COND_W-1:0] JC_IS_CR     = 4'd6;
  localparam logic [COND_W-1:0] JC_NOT_PRINT = 4'd7;
  localparam logic [COND_W-1:0] JC_ROW_VALID = 4'd8;
  localparam logic [COND_W-1:0] JC_FILL_MORE = 4'd9;
  localparam logic [COND_W-1:0] JC_NO_WRAP   = 4'd10;

  // Microprogram step addresses
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] S_DONE     = 4'd0;
  localparam logic [UPC_W-1:0] S_IDLE     = 4'd1;
  localparam logic [UPC_W-1:0] S_DEC_RD   = 4'd2;
  localparam logic [UPC_W-1:0] S_DEC_CLR  = 4'd3;
  localparam logic [UPC_W-1:0] S_DEC_CR   = 4'd4;
  localparam logic [UPC_W-1:0] S_DEC_PR   = 4'd5;
  localparam logic [UPC_W-1:0] S_CHK_ROW  = 4'd6;
  localparam logic [UPC_W-1:0] S_FILL     = 4'd7;
  localparam logic [UPC_W-1:0] S_WRITE    = 4'd8;
  localparam logic [UPC_W-1:0] S_NEWL     = 4'd9;
  localparam logic [UPC_W-1:0] S_RDADDR   = 4'd10;
  localparam logic [UPC_W-1:0] S_RDCAP    = 4'd11;
  localparam logic [UPC_W-1:0] S_CLEAR    = 4'd12;

  // Payload types
  typedef struct packed {
    logic [1:0]        op;
    logic [7:0]        char_in;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
    logic [ROW_W-1:0]  cur_row;
    logic [COL_W-1:0]  cur_col;
  } out_item_t;

  // Microcode word
  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [UPC_W-1:0]  tgt;
  } uword_t;

  // Sequencer to datapath control
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             load;
  } ctl_t;

  // Datapath to sequencer status
  typedef struct packed {
    logic out_busy;
    logic op_read;
    logic op_clear;
    logic is_cr;
    logic is_print;
    logic row_valid;
    logic fill_more;
    logic no_wrap;
  } stat_t;

  // Control store: jump to tgt when cond holds, else step to the next word
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    begin
      unique case (upc)
        S_DONE:    w = '{act: A_EMIT,   cond: JC_OUT_BUSY,  tgt: S_DONE};
        S_IDLE:    w = '{act: A_LOAD,   cond: JC_NO_REQ,    tgt: S_IDLE};
        S_DEC_RD:  w = '{act: A_NONE,   cond: JC_OP_READ,   tgt: S_RDADDR};
        S_DEC_CLR: w = '{act: A_NONE,   cond: JC_OP_CLEAR,  tgt: S_CLEAR};
        S_DEC_CR:  w = '{act: A_NONE,   cond: JC_IS_CR,     tgt: S_NEWL};
        S_DEC_PR:  w = '{act: A_NONE,   cond: JC_NOT_PRINT, tgt: S_DONE};
        S_CHK_ROW: w = '{act: A_NONE,   cond: JC_ROW_VALID, tgt: S_WRITE};
        S_FILL:    w = '{act: A_FILL,   cond: JC_FILL_MORE, tgt: S_FILL};
        S_WRITE:   w = '{act: A_WRITE,  cond: JC_NO_WRAP,   tgt: S_DONE};
        S_NEWL:    w = '{act: A_NEWL,   cond: JC_ALWAYS,    tgt: S_DONE};
        S_RDADDR:  w = '{act: A_RDADDR, cond: JC_NEVER,     tgt: S_DONE};
        S_RDCAP:   w = '{act: A_RDCAP,  cond: JC_ALWAYS,    tgt: S_DONE};
        S_CLEAR:   w = '{act: A_CLEAR,  cond: JC_ALWAYS,    tgt: S_DONE};
        default:   w = '{act: A_NONE,   cond: JC_ALWAYS,    tgt: S_DONE};
      endcase
      return w;
    end
  endfunction

  // Map a screen row onto its physical line in the ring of lines
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] row);
    logic [ROW_W:0] sum;
    begin
      sum = {1'b0, top} + {1'b0, row};
      if (sum >= (ROW_W+1)'(ROWS)) begin
        sum = sum - (ROW_W+1)'(ROWS);
      end
      return sum[ROW_W-1:0];
    end
  endfunction

  // Cell address of a physical line and a column
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                  input logic [COL_W-1:0] col);
    begin
      return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLS) + ADDR_W'(col));
    end
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ttcs_useq.sv
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on ttcs_pkg.
`default_nettype none

module ttcs_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  input  wire ttcs_pkg::stat_t stat,
  output logic                in_ready,
  output ttcs_pkg::ctl_t      ctl
);

  logic [ttcs_pkg::UPC_W-1:0] upc_r;
  logic [ttcs_pkg::UPC_W-1:0] upc_nxt;
  ttcs_pkg::uword_t           uw;
  logic                       take;

  // Fetch the current control word
  assign uw = ttcs_pkg::ucode(upc_r);

  // Select the jump condition
  always_comb begin
    unique case (uw.cond)
      ttcs_pkg::JC_NEVER:     take = 1'b0;
      ttcs_pkg::JC_ALWAYS:    take = 1'b1;
      ttcs_pkg::JC_OUT_BUSY:  take = stat.out_busy;
      ttcs_pkg::JC_NO_REQ:    take = !in_valid;
      ttcs_pkg::JC_OP_READ:   take = stat.op_read;
      ttcs_pkg::JC_OP_CLEAR:  take = stat.op_clear;
      ttcs_pkg::JC_IS_CR:     take = stat.is_cr;
      ttcs_pkg::JC_NOT_PRINT: take = !stat.is_print;
      ttcs_pkg::JC_ROW_VALID: take = stat.row_valid;
      ttcs_pkg::JC_FILL_MORE: take = stat.fill_more;
      ttcs_pkg::JC_NO_WRAP:   take = stat.no_wrap;
      default:                take = 1'b1;
    endcase
    upc_nxt = take ? uw.tgt : upc_r + ttcs_pkg::UPC_W'(1);
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ttcs_pkg::S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  // Drive datapath control
  assign in_ready = (upc_r == ttcs_pkg::S_IDLE);
  assign ctl.act  = uw.act;
  assign ctl.load = in_ready && in_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/ttcs_datapath.sv
// Datapath: cursor and ring registers, row valid bits, screen memory, result register.
// Depends on ttcs_pkg; driven by ttcs_useq.
`default_nettype none

module ttcs_datapath (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ttcs_pkg::ctl_t      ctl,
  input  wire ttcs_pkg::in_item_t  in_data,
  input  wire logic                out_ready,
  output ttcs_pkg::stat_t          stat,
  output logic                     out_valid,
  output ttcs_pkg::out_item_t      out_data
);

  localparam logic [ttcs_pkg::ROW_W-1:0] ROW_LAST = ttcs_pkg::ROW_W'(ttcs_pkg::ROWS - 1);
  localparam logic [ttcs_pkg::COL_W-1:0] COL_LAST = ttcs_pkg::COL_W'(ttcs_pkg::COLS - 1);

  ttcs_pkg::in_item_t              item_r;
  logic [ttcs_pkg::ROW_W-1:0]      top_r;
  logic [ttcs_pkg::ROW_W-1:0]      crow_r;
  logic [ttcs_pkg::COL_W-1:0]      ccol_r;
  logic [ttcs_pkg::COL_W-1:0]      scol_r;
  logic [ttcs_pkg::ROWS-1:0]       valid_r;
  logic [ttcs_pkg::CHAR_W-1:0]     cell_r;
  logic                            out_valid_r;
  ttcs_pkg::out_item_t             out_r;
  logic [ttcs_pkg::CHAR_W-1:0]     rdata_r;
  logic [ttcs_pkg::CHAR_W-1:0]     screen_r [ttcs_pkg::CELLS];

  logic [ttcs_pkg::CHAR_W-1:0]     ch;
  logic [ttcs_pkg::ROW_W-1:0]      cur_phys;
  logic [ttcs_pkg::ROW_W-1:0]      rd_phys;
  logic                            rd_in_range;
  logic                            out_busy;
  logic                            emit;
  logic                            mem_we;
  logic [ttcs_pkg::ADDR_W-1:0]     mem_waddr;
  logic [ttcs_pkg::CHAR_W-1:0]     mem_wdata;
  logic                            mem_re;
  logic [ttcs_pkg::ADDR_W-1:0]     mem_raddr;

  // Decode the held request
  assign ch          = item_r.char_in[ttcs_pkg::CHAR_W-1:0];
  assign cur_phys    = ttcs_pkg::phys_row(top_r, crow_r);
  assign rd_phys     = ttcs_pkg::phys_row(top_r, item_r.read_row);
  assign rd_in_range = (item_r.read_row < ttcs_pkg::ROW_W'(ttcs_pkg::ROWS)) &&
                       (item_r.read_col < ttcs_pkg::COL_W'(ttcs_pkg::COLS));
  assign out_busy    = out_valid_r && !out_ready;
  assign emit        = (ctl.act == ttcs_pkg::A_EMIT) && !out_busy;

  // Report status to the sequencer
  always_comb begin
    stat.out_busy  = out_busy;
    stat.op_read   = (item_r.op == ttcs_pkg::OP_READ);
    stat.op_clear  = (item_r.op == ttcs_pkg::OP_CLEAR);
    stat.is_cr     = (item_r.op == ttcs_pkg::OP_PUT) && (ch == ttcs_pkg::CODE_CR);
    stat.is_print  = (item_r.op == ttcs_pkg::OP_PUT) &&
                     (ch >= ttcs_pkg::CODE_LOW) && (ch <= ttcs_pkg::CODE_HIGH);
    stat.row_valid = valid_r[cur_phys];
    stat.fill_more = (scol_r != COL_LAST);
    stat.no_wrap   = (ccol_r != COL_LAST);
  end

  // Steer the memory ports
  always_comb begin
    mem_we    = (ctl.act == ttcs_pkg::A_FILL) || (ctl.act == ttcs_pkg::A_WRITE);
    mem_waddr = ttcs_pkg::cell_addr(cur_phys,
                  (ctl.act == ttcs_pkg::A_FILL) ? scol_r : ccol_r);
    mem_wdata = (ctl.act == ttcs_pkg::A_FILL) ? ttcs_pkg::CODE_SPACE : ch;
    mem_re    = (ctl.act == ttcs_pkg::A_RDADDR);
    mem_raddr = rd_in_range ? ttcs_pkg::cell_addr(rd_phys, item_r.read_col) : '0;
  end

  // Screen memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_r[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= screen_r[mem_raddr];
    end
  end

  // Hold the request and the read result
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_r <= in_data;
      cell_r <= ttcs_pkg::CODE_SPACE;
    end else if (ctl.act == ttcs_pkg::A_RDCAP) begin
      cell_r <= (rd_in_range && valid_r[rd_phys]) ? rdata_r : ttcs_pkg::CODE_SPACE;
    end
  end

  // Update cursor, ring top, fill column and row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= '0;
      crow_r  <= '0;
      ccol_r  <= '0;
      scol_r  <= '0;
      valid_r <= '0;
    end else begin
      unique case (ctl.act)
        ttcs_pkg::A_FILL: begin
          if (scol_r == COL_LAST) begin
            scol_r            <= '0;
            valid_r[cur_phys] <= 1'b1;
          end else begin
            scol_r <= scol_r + ttcs_pkg::COL_W'(1);
          end
        end
        ttcs_pkg::A_WRITE: begin
          ccol_r <= ccol_r + ttcs_pkg::COL_W'(1);
        end
        ttcs_pkg::A_NEWL: begin
          ccol_r <= '0;
          if (crow_r == ROW_LAST) begin
            // scroll: old top line is blanked and becomes the bottom line
            valid_r[top_r] <= 1'b0;
            top_r          <= (top_r == ROW_LAST) ? '0 : top_r + ttcs_pkg::ROW_W'(1);
          end else begin
            crow_r <= crow_r + ttcs_pkg::ROW_W'(1);
          end
        end
        ttcs_pkg::A_CLEAR: begin
          top_r   <= '0;
          crow_r  <= '0;
          ccol_r  <= '0;
          valid_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r.cell_char <= cell_r;
      out_r.cur_row   <= crow_r;
      out_r.cur_col   <= ccol_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

FILE: hw/rtl/text_terminal_cursor_scroll.sv
// Top level of the 24 x 40 character terminal with cursor and scrolling.
// Depends on ttcs_pkg, ttcs_useq, ttcs_datapath and the defines header.
`default_nettype none

// One request in, one result out. A microcoded sequencer works on one request
// at a time, whether a read, a clear, a carriage return, a printable character
// or an ignored code. The first character written into a line that has been
// blanked since reset, a clear or a scroll first has the line filled with
// spaces through the single memory write port. Line blanking on scroll and
// clear is done by per-line valid bits, so no clearing pass follows reset. A
// finished result waits in an output register; the next request is taken as
// soon as the sequencer is back at its idle step.

`include "text_terminal_cursor_scroll_defines.svh"

module text_terminal_cursor_scroll (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ttcs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ttcs_pkg::out_item_t      out_data
);

  ttcs_pkg::ctl_t  ctl;
  ttcs_pkg::stat_t stat;

  // Sequencer
  ttcs_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctl      (ctl)
  );

  // Datapath
  ttcs_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A taken request leaves the idle step
  `TTCS_ASSERT_NEXT(a_leave_idle, clk, rst_n, in_valid && in_ready, !in_ready)

  // A new result appears together with the return to idle
  `TTCS_ASSERT_NOW(a_result_idle, clk, rst_n, $rose(out_valid), in_ready)

  // Reported cursor stays on the screen
  `TTCS_ASSERT_NOW(a_cursor_range, clk, rst_n, out_valid,
    (out_data.cur_row < ttcs_pkg::ROW_W'(ttcs_pkg::ROWS)) &&
    (out_data.cur_col < ttcs_pkg::COL_W'(ttcs_pkg::COLS)))

endmodule

`default_nettype wire
